[rtl/core/nearest_point_matcher_top_defines.svh]
// Assertion macros for the nearest point matcher.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef NEAREST_POINT_MATCHER_TOP_DEFINES_SVH
`define NEAREST_POINT_MATCHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define NPM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
`define NPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define NPM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define NPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/npm_pkg.sv]
// Shared constants, opcodes and the cell control struct of the nearest point matcher.
// No dependencies.
package npm_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam int COORD_WIDTH_DEF = 16;

   localparam int OP_W   = 2;
   localparam int POS_W  = 16;
   localparam int TAG_W  = 8;
   localparam int DIST_W = 34;
   localparam int LIM_W  = 16;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_MATCH = 2'd2;

   // Cycles from the last entry leaving the ring until the best entry is final
   localparam int DRAIN_CYCLES = 3;
   localparam int DRAIN_W      = 2;

   typedef struct packed {
      logic clear;
      logic load;
      logic rotate;
      logic remove;
   } cell_ctrl_type;

endpackage

[rtl/core/npm_ifs.sv]
// Valid/ready channel interfaces for the request and response beats.
// Depends on npm_pkg.
interface npm_req_if;
   logic                                valid;
   logic                                ready;
   logic [npm_pkg::OP_W-1:0]            opcode;
   logic signed [npm_pkg::POS_W-1:0]    pos_x;
   logic signed [npm_pkg::POS_W-1:0]    pos_y;
   logic signed [npm_pkg::POS_W-1:0]    pos_z;
   logic [npm_pkg::TAG_W-1:0]           point_tag;

   modport source (output valid, opcode, pos_x, pos_y, pos_z, point_tag, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, pos_z, point_tag, output ready);
endinterface

interface npm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                matched;
   logic [npm_pkg::TAG_W-1:0]           match_tag;
   logic [npm_pkg::DIST_W-1:0]          match_dist_sq;

   modport source (output valid, matched, match_tag, match_dist_sq, input ready);
   modport sink   (input valid, matched, match_tag, match_dist_sq, output ready);
endinterface

[rtl/core/npm_cell.sv]
// One table cell of the matcher ring: holds a tracked point, its tag and a valid bit.
// Depends on npm_pkg.
module npm_cell #(
   parameter int COORD_WIDTH = npm_pkg::COORD_WIDTH_DEF,
   parameter int IDX_W       = 4,
   parameter int CELL_IDX    = 0,
   parameter bit IS_LAST     = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  npm_pkg::cell_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]              load_idx,
   input  logic [IDX_W-1:0]              remove_idx,
   input  logic [COORD_WIDTH-1:0]        load_x,
   input  logic [COORD_WIDTH-1:0]        load_y,
   input  logic [COORD_WIDTH-1:0]        load_z,
   input  logic [npm_pkg::TAG_W-1:0]     load_tag,
   input  logic [COORD_WIDTH-1:0]        nb_x,
   input  logic [COORD_WIDTH-1:0]        nb_y,
   input  logic [COORD_WIDTH-1:0]        nb_z,
   input  logic [npm_pkg::TAG_W-1:0]     nb_tag,
   input  logic                          nb_valid,
   output logic [COORD_WIDTH-1:0]        x,
   output logic [COORD_WIDTH-1:0]        y,
   output logic [COORD_WIDTH-1:0]        z,
   output logic [npm_pkg::TAG_W-1:0]     tag,
   output logic                          valid
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [COORD_WIDTH-1:0]    x_ff, x_in;
   logic [COORD_WIDTH-1:0]    y_ff, y_in;
   logic [COORD_WIDTH-1:0]    z_ff, z_in;
   logic [npm_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic                      valid_ff, valid_in;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      tag_in   = tag_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.load && (load_idx == MY_IDX)) begin
         x_in     = load_x;
         y_in     = load_y;
         z_in     = load_z;
         tag_in   = load_tag;
         valid_in = 1'b1;
      end else if (ctrl.rotate) begin
         x_in     = nb_x;
         y_in     = nb_y;
         z_in     = nb_z;
         tag_in   = nb_tag;
         valid_in = nb_valid;
      end else if (ctrl.remove && (MY_IDX >= remove_idx)) begin
         // close the gap: take the entry above, the top cell empties
         if (IS_LAST) begin
            valid_in = 1'b0;
         end else begin
            x_in     = nb_x;
            y_in     = nb_y;
            z_in     = nb_z;
            tag_in   = nb_tag;
            valid_in = nb_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      tag_ff <= tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign x     = x_ff;
   assign y     = y_ff;
   assign z     = z_ff;
   assign tag   = tag_ff;
   assign valid = valid_ff;

endmodule

[rtl/core/npm_dist.sv]
// Squared-distance pipeline and nearest-entry tracker fed from the head of the cell ring.
// Depends on npm_pkg.
module npm_dist #(
   parameter int COORD_WIDTH = npm_pkg::COORD_WIDTH_DEF,
   parameter int IDX_W       = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          feed_valid,
   input  logic [IDX_W-1:0]              feed_idx,
   input  logic [COORD_WIDTH-1:0]        ent_x,
   input  logic [COORD_WIDTH-1:0]        ent_y,
   input  logic [COORD_WIDTH-1:0]        ent_z,
   input  logic [npm_pkg::TAG_W-1:0]     ent_tag,
   input  logic [COORD_WIDTH-1:0]        pt_x,
   input  logic [COORD_WIDTH-1:0]        pt_y,
   input  logic [COORD_WIDTH-1:0]        pt_z,
   output logic                          found,
   output logic [IDX_W-1:0]              best_idx,
   output logic [npm_pkg::TAG_W-1:0]     best_tag,
   output logic [2*COORD_WIDTH+1:0]      best_dist
);

   localparam int CW = COORD_WIDTH;
   localparam int SW = 2 * CW + 1;
   localparam int DW = 2 * CW + 2;

   // stage 1: differences
   logic                      v1_ff;
   logic signed [CW:0]        dx1_ff, dx1_in;
   logic signed [CW:0]        dy1_ff, dy1_in;
   logic signed [CW:0]        dz1_ff, dz1_in;
   logic [IDX_W-1:0]          idx1_ff;
   logic [npm_pkg::TAG_W-1:0] tag1_ff;
   // stage 2: squares
   logic                      v2_ff;
   logic signed [DW-1:0]      px2, py2, pz2;
   logic [SW-1:0]             sx2_ff, sy2_ff, sz2_ff;
   logic [IDX_W-1:0]          idx2_ff;
   logic [npm_pkg::TAG_W-1:0] tag2_ff;
   // stage 3: sum
   logic                      v3_ff;
   logic [DW-1:0]             sum3_ff, sum3_in;
   logic [IDX_W-1:0]          idx3_ff;
   logic [npm_pkg::TAG_W-1:0] tag3_ff;
   // tracker
   logic                      found_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic [npm_pkg::TAG_W-1:0] best_tag_ff;
   logic [DW-1:0]             best_dist_ff;
   logic                      take;

   assign dx1_in = $signed({ent_x[CW-1], ent_x}) - $signed({pt_x[CW-1], pt_x});
   assign dy1_in = $signed({ent_y[CW-1], ent_y}) - $signed({pt_y[CW-1], pt_y});
   assign dz1_in = $signed({ent_z[CW-1], ent_z}) - $signed({pt_z[CW-1], pt_z});

   assign px2 = dx1_ff * dx1_ff;
   assign py2 = dy1_ff * dy1_ff;
   assign pz2 = dz1_ff * dz1_ff;

   assign sum3_in = DW'(sx2_ff) + DW'(sy2_ff) + DW'(sz2_ff);

   // strict less keeps the earliest entry on a tie
   assign take = v3_ff && (!found_ff || (sum3_ff < best_dist_ff));

   always_ff @(posedge clock) begin
      dx1_ff  <= dx1_in;
      dy1_ff  <= dy1_in;
      dz1_ff  <= dz1_in;
      idx1_ff <= feed_idx;
      tag1_ff <= ent_tag;
      sx2_ff  <= px2[SW-1:0];
      sy2_ff  <= py2[SW-1:0];
      sz2_ff  <= pz2[SW-1:0];
      idx2_ff <= idx1_ff;
      tag2_ff <= tag1_ff;
      sum3_ff <= sum3_in;
      idx3_ff <= idx2_ff;
      tag3_ff <= tag2_ff;
      if (take) begin
         best_idx_ff  <= idx3_ff;
         best_tag_ff  <= tag3_ff;
         best_dist_ff <= sum3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         v1_ff <= feed_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (start) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   assign found     = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_tag  = best_tag_ff;
   assign best_dist = best_dist_ff;

endmodule

[rtl/core/nearest_point_matcher_top.sv]
// Top level of the nearest point matcher: control, cell ring and distance pipeline.
// Depends on npm_pkg, npm_ifs, npm_cell, npm_dist and the assertion macro header.
//
// Usage:
//  - req_chan carries one command per beat: clear the table, load a tracked point
//    with its tag, or match a new point against the table.
//  - rsp_chan returns one beat per match: matched flag, tag of the matched entry
//    and the smallest squared distance. Clear and load give no beat.
//  - csr_wen/csr_wdata set the match limit; write only while the block is idle.
//  - Clear and load leave the block idle; the next beat is taken in the next cycle.
//  - A match runs from acceptance to the response beat in steps: the table ring
//    rotates once through the single squared-distance unit, one entry a cycle,
//    then the three-stage pipeline drains and the decide state writes the response
//    and removes the matched entry, if any.
//  - The response sits in an output register; loads and clears are still taken
//    while it waits, and a following match holds in its decide cycle until the
//    receiver takes the previous response.
//  - Reset empties the table, clears the limit and drops any pending response.
`include "nearest_point_matcher_top_defines.svh"
module nearest_point_matcher_top #(
   parameter int TABLE_DEPTH = npm_pkg::TABLE_DEPTH_DEF,
   parameter int COORD_WIDTH = npm_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   npm_req_if.sink                       req_chan,
   npm_rsp_if.source                     rsp_chan,
   input  logic                          csr_wen,
   input  logic [npm_pkg::LIM_W-1:0]     csr_wdata
);

   localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int FW     = $clog2(TABLE_DEPTH + 1);
   localparam int CW     = COORD_WIDTH;
   localparam int DW     = 2 * CW + 2;
   localparam int LW     = 2 * npm_pkg::LIM_W;
   localparam int CMPW   = (DW > LW) ? DW : LW;
   localparam int OUT_DW = npm_pkg::DIST_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [FW-1:0]                 fill_ff, fill_in;
   logic [IW-1:0]                 scan_cnt_ff, scan_cnt_in;
   logic [npm_pkg::DRAIN_W-1:0]   drain_cnt_ff, drain_cnt_in;
   logic [CW-1:0]                 pt_x_ff, pt_y_ff, pt_z_ff;
   logic [LW-1:0]                 lim_ff, lim_in;
   logic                          rsp_valid_ff;
   logic                          rsp_matched_ff;
   logic [npm_pkg::TAG_W-1:0]     rsp_tag_ff;
   logic [OUT_DW-1:0]             rsp_dist_ff;

   logic                          accept;
   logic                          rsp_load;
   logic                          hit;
   logic                          dist_start;
   logic                          feed_valid;
   npm_pkg::cell_ctrl_type        ctrl;
   logic [CW-1:0]                 load_x, load_y, load_z;

   logic [CW-1:0]                 cx   [TABLE_DEPTH];
   logic [CW-1:0]                 cy   [TABLE_DEPTH];
   logic [CW-1:0]                 cz   [TABLE_DEPTH];
   logic [npm_pkg::TAG_W-1:0]     ctag [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]        cv;

   logic                          found;
   logic [IW-1:0]                 best_idx;
   logic [npm_pkg::TAG_W-1:0]     best_tag;
   logic [DW-1:0]                 best_dist;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign load_x = CW'($unsigned(req_chan.pos_x));
   assign load_y = CW'($unsigned(req_chan.pos_y));
   assign load_z = CW'($unsigned(req_chan.pos_z));

   assign feed_valid = (state_ff == S_SCAN) && cv[0];
   assign hit        = found && (CMPW'(best_dist) <= CMPW'(lim_ff));
   assign lim_in     = LW'(csr_wdata) * LW'(csr_wdata);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      scan_cnt_in  = scan_cnt_ff;
      drain_cnt_in = drain_cnt_ff;
      ctrl         = '0;
      dist_start   = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_chan.opcode)
                  npm_pkg::OP_CLEAR: begin
                     ctrl.clear = 1'b1;
                     fill_in    = '0;
                  end
                  npm_pkg::OP_LOAD: begin
                     // drop the load when the table is full
                     if (fill_ff < FW'(TABLE_DEPTH)) begin
                        ctrl.load = 1'b1;
                        fill_in   = fill_ff + 1'b1;
                     end
                  end
                  npm_pkg::OP_MATCH: begin
                     state_in    = S_SCAN;
                     scan_cnt_in = '0;
                     dist_start  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one full turn of the ring brings every entry back to its own cell
            ctrl.rotate = 1'b1;
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == IW'(TABLE_DEPTH - 1)) begin
               state_in     = S_DRAIN;
               drain_cnt_in = '0;
            end
         end
         S_DRAIN: begin
            drain_cnt_in = drain_cnt_ff + 1'b1;
            if (drain_cnt_ff == npm_pkg::DRAIN_W'(npm_pkg::DRAIN_CYCLES - 1)) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (hit) begin
                  ctrl.remove = 1'b1;
                  fill_in     = fill_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         scan_cnt_ff  <= '0;
         drain_cnt_ff <= '0;
         lim_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         scan_cnt_ff  <= scan_cnt_in;
         drain_cnt_ff <= drain_cnt_in;
         if (csr_wen) begin
            lim_ff <= lim_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pt_x_ff <= load_x;
         pt_y_ff <= load_y;
         pt_z_ff <= load_z;
      end
      if (rsp_load) begin
         rsp_matched_ff <= hit;
         rsp_tag_ff     <= hit ? best_tag : '0;
         rsp_dist_ff    <= found ? OUT_DW'(best_dist) : '0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.matched       = rsp_matched_ff;
   assign rsp_chan.match_tag     = rsp_tag_ff;
   assign rsp_chan.match_dist_sq = rsp_dist_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam int NB = (i + 1) % TABLE_DEPTH;
      npm_cell #(
         .COORD_WIDTH (CW),
         .IDX_W       (IW),
         .CELL_IDX    (i),
         .IS_LAST     (i == TABLE_DEPTH - 1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load_idx   (fill_ff[IW-1:0]),
         .remove_idx (best_idx),
         .load_x     (load_x),
         .load_y     (load_y),
         .load_z     (load_z),
         .load_tag   (req_chan.point_tag),
         .nb_x       (cx[NB]),
         .nb_y       (cy[NB]),
         .nb_z       (cz[NB]),
         .nb_tag     (ctag[NB]),
         .nb_valid   (cv[NB]),
         .x          (cx[i]),
         .y          (cy[i]),
         .z          (cz[i]),
         .tag        (ctag[i]),
         .valid      (cv[i])
      );
   end

   npm_dist #(
      .COORD_WIDTH (CW),
      .IDX_W       (IW)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .start      (dist_start),
      .feed_valid (feed_valid),
      .feed_idx   (scan_cnt_ff),
      .ent_x      (cx[0]),
      .ent_y      (cy[0]),
      .ent_z      (cz[0]),
      .ent_tag    (ctag[0]),
      .pt_x       (pt_x_ff),
      .pt_y       (pt_y_ff),
      .pt_z       (pt_z_ff),
      .found      (found),
      .best_idx   (best_idx),
      .best_tag   (best_tag),
      .best_dist  (best_dist)
   );

   `NPM_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(TABLE_DEPTH))
   `NPM_ASSERT_IMPLY(a_table_packed, clock, reset, 1'b1, $countones(cv) == int'(fill_ff))
   `NPM_ASSERT_NEXT(a_rsp_from_decide, clock, reset, !rsp_valid_ff && state_ff != S_DECIDE, !rsp_valid_ff)
   `NPM_ASSERT_IMPLY(a_hit_within_limit, clock, reset, rsp_valid_ff && rsp_matched_ff, rsp_dist_ff <= OUT_DW'(lim_ff))

endmodule

[verif/tb_nearest_point_matcher_top.sv]
// Testbench for nearest_point_matcher_top: directed and random clear, load and match beats,
// with every response checked against a table of tracked points kept in this file.
// Depends on npm_pkg, npm_ifs and the matcher RTL.
module tb_nearest_point_matcher_top;

   localparam int DEPTH = npm_pkg::TABLE_DEPTH_DEF;
   localparam logic [npm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = DEPTH + 12;
   localparam int ITEM_TARGET = 1950;
   localparam int N_PHASES = 6;

   typedef struct packed {
      logic [npm_pkg::OP_W-1:0]         opcode;
      logic signed [npm_pkg::POS_W-1:0] pos_x;
      logic signed [npm_pkg::POS_W-1:0] pos_y;
      logic signed [npm_pkg::POS_W-1:0] pos_z;
      logic [npm_pkg::TAG_W-1:0]        point_tag;
   } point_cmd_type;

   typedef struct packed {
      logic                       matched;
      logic [npm_pkg::TAG_W-1:0]  match_tag;
      logic [npm_pkg::DIST_W-1:0] match_dist_sq;
   } match_result_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wen;
   logic [npm_pkg::LIM_W-1:0] csr_wdata;

   npm_req_if req_bus();
   npm_rsp_if rsp_bus();

   nearest_point_matcher_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   // Tracked point table, kept packed in load order
   logic signed [npm_pkg::POS_W-1:0] trk_x [DEPTH];
   logic signed [npm_pkg::POS_W-1:0] trk_y [DEPTH];
   logic signed [npm_pkg::POS_W-1:0] trk_z [DEPTH];
   logic [npm_pkg::TAG_W-1:0]        trk_tag [DEPTH];
   int                               trk_count = 0;
   longint                           move_limit = 0;

   point_cmd_type    pending_cmds[$];
   match_result_type expected_matches[$];
   point_cmd_type    cur_cmd;

   bit idle_en = 1'b1;
   bit req_taken = 1'b0;
   bit req_busy = 1'b0;
   int req_gap = 0;
   int rsp_gap = 0;
   int rsp_hold_cycles = 0;
   int items_queued = 0;
   int n_errors = 0;
   int n_results = 0;
   int n_clears = 0;
   int n_loads = 0;
   int n_dropped = 0;
   int n_matches = 0;
   int n_hits = 0;
   int n_limits = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout: %0d results still awaited", expected_matches.size());
      $display("Some tests failed");
      $finish;
   end

   // Update the table on each accepted beat and queue the response it causes
   always @(posedge clock) begin : accept_and_predict
      longint dx, dy, dz, dist_sq, best_sq;
      int best;
      match_result_type res;
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_taken = 1'b1;
         case (cur_cmd.opcode)
            npm_pkg::OP_CLEAR: begin
               trk_count = 0;
               n_clears++;
            end
            npm_pkg::OP_LOAD: begin
               if (trk_count < DEPTH) begin
                  trk_x[trk_count] = cur_cmd.pos_x;
                  trk_y[trk_count] = cur_cmd.pos_y;
                  trk_z[trk_count] = cur_cmd.pos_z;
                  trk_tag[trk_count] = cur_cmd.point_tag;
                  trk_count++;
                  n_loads++;
               end else begin
                  n_dropped++;
               end
            end
            npm_pkg::OP_MATCH: begin
               best = -1;
               best_sq = 0;
               for (int i = 0; i < trk_count; i++) begin
                  dx = longint'(trk_x[i]) - longint'(cur_cmd.pos_x);
                  dy = longint'(trk_y[i]) - longint'(cur_cmd.pos_y);
                  dz = longint'(trk_z[i]) - longint'(cur_cmd.pos_z);
                  dist_sq = dx * dx + dy * dy + dz * dz;
                  // strict compare keeps the earliest entry on a tie
                  if (best < 0 || dist_sq < best_sq) begin
                     best = i;
                     best_sq = dist_sq;
                  end
               end
               res = '0;
               if (best >= 0)
                  res.match_dist_sq = best_sq[npm_pkg::DIST_W-1:0];
               if (best >= 0 && best_sq <= move_limit * move_limit) begin
                  res.matched = 1'b1;
                  res.match_tag = trk_tag[best];
                  for (int i = best; i < trk_count - 1; i++) begin
                     trk_x[i] = trk_x[i+1];
                     trk_y[i] = trk_y[i+1];
                     trk_z[i] = trk_z[i+1];
                     trk_tag[i] = trk_tag[i+1];
                  end
                  trk_count--;
                  n_hits++;
               end
               n_matches++;
               expected_matches.push_back(res);
            end
            default: ;
         endcase
      end
   end

   always @(negedge clock) begin : drive_requests
      logic next_valid;
      next_valid = req_bus.valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_cmds.size() != 0) begin
            cur_cmd = pending_cmds.pop_front();
            req_bus.opcode <= cur_cmd.opcode;
            req_bus.pos_x <= cur_cmd.pos_x;
            req_bus.pos_y <= cur_cmd.pos_y;
            req_bus.pos_z <= cur_cmd.pos_z;
            req_bus.point_tag <= cur_cmd.point_tag;
            next_valid = 1'b1;
            if (idle_en && $urandom_range(0, 7) == 0)
               req_gap = $urandom_range(1, 6);
         end
      end
      req_taken = 1'b0;
      req_busy = next_valid;
      req_bus.valid <= next_valid;
   end

   always @(negedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(1, 6) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      match_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_results++;
         if (expected_matches.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("Unexpected response beat: matched %0d tag %0d dist_sq %0d",
                        rsp_bus.matched, rsp_bus.match_tag, rsp_bus.match_dist_sq);
         end else begin
            want = expected_matches.pop_front();
            if (rsp_bus.matched !== want.matched || rsp_bus.match_tag !== want.match_tag ||
                rsp_bus.match_dist_sq !== want.match_dist_sq) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("Mismatch on response %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           n_results, want.matched, want.match_tag, want.match_dist_sq,
                           rsp_bus.matched, rsp_bus.match_tag, rsp_bus.match_dist_sq);
            end
         end
      end
   end

   task automatic push_cmd(logic [npm_pkg::OP_W-1:0] op, int x, int y, int z, int tag);
      point_cmd_type c;
      c.opcode = op;
      c.pos_x = x[npm_pkg::POS_W-1:0];
      c.pos_y = y[npm_pkg::POS_W-1:0];
      c.pos_z = z[npm_pkg::POS_W-1:0];
      c.point_tag = tag[npm_pkg::TAG_W-1:0];
      pending_cmds.push_back(c);
      if (op != OP_UNUSED)
         items_queued++;
   endtask

   // Hold until every beat is sent and answered, then let trailing loads settle
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_busy || expected_matches.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(int value);
      csr_wdata <= value[npm_pkg::LIM_W-1:0];
      csr_wen <= 1'b1;
      @(negedge clock);
      csr_wen <= 1'b0;
      move_limit = value & 16'hFFFF;
      n_limits++;
   endtask

   // Optionally clear, load a batch of points around a centre, then match points near them and a few strays
   task automatic run_scene();
      int cx, cy, cz, spread, n_load, n_match, pick, span, lim;
      int lx[$], ly[$], lz[$];
      int x, y, z;
      if ($urandom_range(0, 3) != 0)
         push_cmd(npm_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
      case ($urandom_range(0, 2))
         0: spread = 8;
         1: spread = 2000;
         default: spread = 32768;
      endcase
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      cz = int'($urandom_range(0, 65535)) - 32768;
      n_load = $urandom_range(1, 20);
      for (int k = 0; k < n_load; k++) begin
         if (k > 0 && $urandom_range(0, 9) == 0) begin
            x = lx[k-1];
            y = ly[k-1];
            z = lz[k-1];
         end else begin
            x = cx + int'($urandom_range(0, 2 * spread)) - spread;
            y = cy + int'($urandom_range(0, 2 * spread)) - spread;
            z = cz + int'($urandom_range(0, 2 * spread)) - spread;
         end
         lx.push_back(x);
         ly.push_back(y);
         lz.push_back(z);
         push_cmd(npm_pkg::OP_LOAD, x, y, z, $urandom);
      end
      lim = int'(move_limit);
      span = lim / 2;
      n_match = $urandom_range(1, n_load + 2);
      for (int k = 0; k < n_match; k++) begin
         if ($urandom_range(0, 19) == 0)
            push_cmd(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
         if ($urandom_range(0, 29) == 0)
            push_cmd(npm_pkg::OP_LOAD, $urandom, $urandom, $urandom, $urandom);
         pick = $urandom_range(0, lx.size() - 1);
         x = lx[pick];
         y = ly[pick];
         z = lz[pick];
         case ($urandom_range(0, 9))
            0: ;
            1: x = x + lim;
            2: x = x + lim + 1;
            3: begin
               x = $urandom;
               y = $urandom;
               z = $urandom;
            end
            default: begin
               x = x + int'($urandom_range(0, 2 * span)) - span;
               y = y + int'($urandom_range(0, 2 * span)) - span;
               z = z + int'($urandom_range(0, 2 * span)) - span;
            end
         endcase
         push_cmd(npm_pkg::OP_MATCH, x, y, z, $urandom);
      end
   endtask

   initial begin : stimulus
      int phase_end, n_scenes;
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Limit is zero out of reset: only exact hits match
      push_cmd(npm_pkg::OP_MATCH, 0, 0, 0, 0);
      push_cmd(npm_pkg::OP_LOAD, 32767, 32767, 32767, 255);
      push_cmd(npm_pkg::OP_LOAD, -32768, -32768, -32768, 0);
      push_cmd(npm_pkg::OP_MATCH, -32768, -32768, -32768, 0);
      push_cmd(npm_pkg::OP_MATCH, -32768, -32768, -32768, 0);
      push_cmd(OP_UNUSED, -1, -1, -1, 255);
      push_cmd(npm_pkg::OP_LOAD, 100, -100, 5, 8'h5A);
      push_cmd(npm_pkg::OP_LOAD, 100, -100, 5, 8'hA5);
      push_cmd(npm_pkg::OP_MATCH, 100, -100, 5, 0);
      push_cmd(npm_pkg::OP_MATCH, 100, -100, 5, 0);
      push_cmd(npm_pkg::OP_MATCH, 101, -100, 5, 0);
      push_cmd(npm_pkg::OP_CLEAR, 0, 0, 0, 0);
      push_cmd(npm_pkg::OP_MATCH, 0, 0, 0, 0);
      push_cmd(npm_pkg::OP_LOAD, 0, 0, 0, 1);
      push_cmd(npm_pkg::OP_MATCH, 0, 0, 0, 0);
      push_cmd(npm_pkg::OP_MATCH, 0, 0, 0, 0);
      wait_drained();

      // Widest limit: a point exactly at the limit matches, one step further does not
      write_limit(65535);
      push_cmd(npm_pkg::OP_LOAD, -32768, 0, 0, 3);
      push_cmd(npm_pkg::OP_MATCH, 32767, 0, 0, 0);
      push_cmd(npm_pkg::OP_LOAD, -32768, 0, 0, 4);
      push_cmd(npm_pkg::OP_MATCH, 32767, 0, 1, 0);
      push_cmd(npm_pkg::OP_CLEAR, 0, 0, 0, 0);
      wait_drained();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: write_limit(65535);
            1: write_limit(0);
            2: write_limit(1);
            3: write_limit($urandom_range(2, 300));
            4: write_limit($urandom_range(0, 65535));
            default: write_limit(3000);
         endcase
         // Last phase runs flat out on both sides
         idle_en = (ph != N_PHASES - 1);
         if (ph == 0 || ph == 3) begin
            @(posedge clock);
            rsp_hold_cycles = 400;
            repeat (4) push_cmd(npm_pkg::OP_MATCH, $urandom, $urandom, $urandom, 0);
         end
         phase_end = 25 + (ITEM_TARGET - 25) * (ph + 1) / N_PHASES;
         n_scenes = 0;
         while (items_queued < phase_end) begin
            run_scene();
            n_scenes++;
            if (n_scenes % 8 == 0)
               wait_drained();
         end
         wait_drained();
      end

      $display("Covered %0d clears, %0d loads (%0d dropped on a full table), %0d matches",
               n_clears, n_loads, n_dropped, n_matches);
      $display("with %0d hits, across %0d limit settings; %0d mismatches",
               n_hits, n_limits, n_errors);
      if (n_errors == 0 && expected_matches.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[nearest_point_matcher_top.f]
+incdir+rtl/core
rtl/core/npm_pkg.sv
rtl/core/npm_ifs.sv
rtl/core/npm_cell.sv
rtl/core/npm_dist.sv
rtl/core/nearest_point_matcher_top.sv
verif/tb_nearest_point_matcher_top.sv
